@@ design/pdms_pkg.sv @@
// Package for the PLL divider/multiplier search unit.
// Types, constants and codes shared by the divider, datapath and top level.
package pdms_pkg;

   localparam int WIDE_BITS = 64;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LO_DIV,
      ST_LO_WAIT,
      ST_MAX_DIV,
      ST_MAX_WAIT,
      ST_HI_DIV,
      ST_HI_WAIT,
      ST_Q_DIV,
      ST_Q_WAIT,
      ST_M_DIV,
      ST_M_WAIT,
      ST_EVAL,
      ST_RANGE,
      ST_DONE
   } state_type;

   // configuration register indexes
   localparam logic [2:0] CSR_INPUT_MIN  = 3'd0;
   localparam logic [2:0] CSR_INPUT_MAX  = 3'd1;
   localparam logic [2:0] CSR_MUL_MAX    = 3'd2;
   localparam logic [2:0] CSR_RANGE_CNT  = 3'd3;
   localparam logic [2:0] CSR_RANGE0_MIN = 3'd4;
   localparam logic [2:0] CSR_RANGE0_MAX = 3'd5;
   localparam logic [2:0] CSR_RANGE1_MIN = 3'd6;
   localparam logic [2:0] CSR_RANGE1_MAX = 3'd7;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } div_ctl_type;

endpackage

@@ design/pdms_if.sv @@
// Valid/ready channel interfaces for the search unit.
// Depends on nothing; payload field widths follow the unit's ports.
interface pdms_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] target_rate;
   logic [31:0] reference_rate;
   modport source (output valid, target_rate, reference_rate, input ready);
   modport sink (input valid, target_rate, reference_rate, output ready);
endinterface

interface pdms_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic [31:0] best_rate;
   logic [7:0]  divider;
   logic [15:0] mul_minus_one;
   logic        range_index;
   modport source (output valid, status, best_rate, divider, mul_minus_one, range_index,
                   input ready);
   modport sink (input valid, status, best_rate, divider, mul_minus_one, range_index,
                 output ready);
endinterface

interface pdms_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ design/pll_divider_multiplier_search_unit.sv @@
// PLL divider/multiplier search. Every division runs on one shared restoring divider,
// in a start step, one iteration per quotient bit and a done step. A request needs up
// to three bound divisions. Each candidate divider then takes two divisions and a compare
// step; a divider whose per-divider rate is zero takes only the first division. A request
// rejected up front returns its word once any unread previous word has been taken. One
// request is in work at a time. The result register holds the last word while the next
// request is taken.
// csr writes are accepted in any cycle and must only be issued while the block is idle.
module pll_divider_multiplier_search_unit import pdms_pkg::*; #(
   parameter int DIV_LIMIT = 255
) (
   input  logic        clock,
   input  logic        reset,
   pdms_req_if.sink    req,
   pdms_rsp_if.source  rsp,
   pdms_csr_if.sink    csr
);
   state_type state_ff, state_in;

   logic [31:0] in_min_ff, in_max_ff, r0_min_ff, r0_max_ff, r1_min_ff, r1_max_ff;
   logic [11:0] mul_max_ff;
   logic [1:0]  rcnt_ff;
   logic [31:0] tgt_ff, tgt_in, ref_ff, ref_in;
   logic [8:0]  lo_ff, lo_in, hi_ff, hi_in;
   logic [8:0]  d_ff, d_in;
   logic [31:0] q_ff, q_in;
   logic [WIDE_BITS-1:0] m_ff, m_in;
   logic [WIDE_BITS-1:0] berr_ff, berr_in, bmul_ff, bmul_in, brate_ff, brate_in;
   logic [7:0]  bdiv_ff, bdiv_in;
   logic        found_ff, found_in;
   logic        status_ff, status_in, ridx_ff, ridx_in, valid_ff, valid_in;
   logic [31:0] orate_ff, orate_in;
   logic [7:0]  odiv_ff, odiv_in;
   logic [15:0] omul_ff, omul_in;

   logic                 dstart;
   logic [WIDE_BITS-1:0] dnum, dden, dquo, drem;
   div_ctl_type          dctl;
   logic [WIDE_BITS-1:0] rate, err, cq;
   logic                 in0, in1;

   pdms_divider u_div (.clock, .reset, .start(dstart), .dividend(dnum), .divisor(dden),
      .ctl(dctl), .quotient(dquo), .remainder(drem));

   assign req.ready = (state_ff == ST_IDLE);
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_min_ff  <= '0;
         in_max_ff  <= '1;
         mul_max_ff <= 12'd2048;
         rcnt_ff    <= 2'd1;
         r0_min_ff  <= '0;
         r0_max_ff  <= '1;
         r1_min_ff  <= '0;
         r1_max_ff  <= '1;
      end else if (csr.valid) begin
         unique case (csr.index)
            CSR_INPUT_MIN:  in_min_ff  <= csr.data;
            CSR_INPUT_MAX:  in_max_ff  <= csr.data;
            CSR_MUL_MAX:    mul_max_ff <= csr.data[11:0];
            CSR_RANGE_CNT:  rcnt_ff    <= csr.data[1:0];
            CSR_RANGE0_MIN: r0_min_ff  <= csr.data;
            CSR_RANGE0_MAX: r0_max_ff  <= csr.data;
            CSR_RANGE1_MIN: r1_min_ff  <= csr.data;
            CSR_RANGE1_MAX: r1_max_ff  <= csr.data;
            default: ;
         endcase
      end
   end

   // the rounded multiplier never exceeds 32 bits
   assign rate = WIDE_BITS'(q_ff) * WIDE_BITS'(m_ff[31:0]);
   assign err  = (rate > WIDE_BITS'(tgt_ff)) ? rate - WIDE_BITS'(tgt_ff)
                                             : WIDE_BITS'(tgt_ff) - rate;
   assign cq   = dquo + ((drem != '0) ? WIDE_BITS'(1) : '0);
   assign in0  = brate_ff[31:0] >= r0_min_ff && brate_ff[31:0] <= r0_max_ff;
   assign in1  = brate_ff[31:0] >= r1_min_ff && brate_ff[31:0] <= r1_max_ff;

   always_comb begin
      state_in  = state_ff;
      tgt_in    = tgt_ff;
      ref_in    = ref_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      d_in      = d_ff;
      q_in      = q_ff;
      m_in      = m_ff;
      berr_in   = berr_ff;
      bmul_in   = bmul_ff;
      brate_in  = brate_ff;
      bdiv_in   = bdiv_ff;
      found_in  = found_ff;
      status_in = status_ff;
      ridx_in   = ridx_ff;
      orate_in  = orate_ff;
      odiv_in   = odiv_ff;
      omul_in   = omul_ff;
      valid_in  = valid_ff;
      dstart    = 1'b0;
      dnum      = '0;
      dden      = '1;
      if (valid_ff && rsp.ready) valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               tgt_in   = req.target_rate;
               ref_in   = req.reference_rate;
               berr_in  = '1;
               found_in = 1'b0;
               bmul_in  = '0;
               brate_in = '0;
               bdiv_in  = '0;
               if (req.reference_rate < in_min_ff || req.target_rate == '0)
                  state_in = ST_DONE;
               else
                  state_in = ST_LO_DIV;
            end
         end
         ST_LO_DIV: begin
            dstart   = 1'b1;
            dnum     = WIDE_BITS'({ref_ff, 1'b0});
            dden     = WIDE_BITS'(tgt_ff);
            state_in = ST_LO_WAIT;
         end
         ST_LO_WAIT: if (dctl.done) begin
            // quotient is at most 2^33/1, clamp to a sentinel above the limit
            if (dquo == '0)         lo_in = 9'd1;
            else if (dquo > 64'd256) lo_in = 9'd256;
            else                    lo_in = dquo[8:0];
            if (ref_ff > in_max_ff) begin
               if (in_max_ff == '0) state_in = ST_DONE;
               else                 state_in = ST_MAX_DIV;
            end else
               state_in = ST_HI_DIV;
         end
         ST_MAX_DIV: begin
            dstart   = 1'b1;
            dnum     = WIDE_BITS'(ref_ff);
            dden     = WIDE_BITS'(in_max_ff);
            state_in = ST_MAX_WAIT;
         end
         ST_MAX_WAIT: if (dctl.done) begin
            if (cq > WIDE_BITS'(DIV_LIMIT)) state_in = ST_DONE;
            else begin
               if (cq[8:0] > lo_ff) lo_in = cq[8:0];
               state_in = ST_HI_DIV;
            end
         end
         ST_HI_DIV: begin
            dstart   = 1'b1;
            dnum     = WIDE_BITS'(ref_ff) * WIDE_BITS'(mul_max_ff);
            dden     = WIDE_BITS'(tgt_ff);
            state_in = ST_HI_WAIT;
         end
         ST_HI_WAIT: if (dctl.done) begin
            hi_in    = (cq > WIDE_BITS'(DIV_LIMIT)) ? 9'(DIV_LIMIT) : cq[8:0];
            d_in     = lo_ff;
            state_in = ST_Q_DIV;
         end
         ST_Q_DIV: begin
            if (d_ff > hi_ff) state_in = ST_RANGE;
            else begin
               dstart   = 1'b1;
               dnum     = WIDE_BITS'(ref_ff);
               dden     = WIDE_BITS'(d_ff);
               state_in = ST_Q_WAIT;
            end
         end
         ST_Q_WAIT: if (dctl.done) begin
            q_in = dquo[31:0];
            if (dquo == '0) begin
               d_in     = d_ff + 9'd1;
               state_in = ST_Q_DIV;
            end else
               state_in = ST_M_DIV;
         end
         ST_M_DIV: begin
            dstart   = 1'b1;
            dnum     = WIDE_BITS'(tgt_ff) + WIDE_BITS'(q_ff[31:1]);
            dden     = WIDE_BITS'(q_ff);
            state_in = ST_M_WAIT;
         end
         ST_M_WAIT: if (dctl.done) begin
            m_in     = dquo;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (err < berr_ff) begin
               berr_in  = err;
               bdiv_in  = d_ff[7:0];
               bmul_in  = m_ff;
               brate_in = rate;
               found_in = 1'b1;
            end
            d_in     = d_ff + 9'd1;
            state_in = (err == '0) ? ST_RANGE : ST_Q_DIV;
         end
         // both finishing states wait here while the previous word is still unread
         ST_RANGE: if (!valid_ff || rsp.ready) begin
            status_in = STATUS_FAIL;
            ridx_in   = 1'b0;
            orate_in  = '0;
            odiv_in   = '0;
            omul_in   = '0;
            if (found_ff && bmul_ff != '0 && bmul_ff <= WIDE_BITS'(mul_max_ff)
                && brate_ff[63:32] == '0 && rcnt_ff != 2'd0
                && (in0 || (rcnt_ff != 2'd1 && in1))) begin
               status_in = STATUS_OK;
               ridx_in   = !in0;
               orate_in  = brate_ff[31:0];
               odiv_in   = bdiv_ff;
               omul_in   = 16'(bmul_ff - WIDE_BITS'(1));
            end
            valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         ST_DONE: if (!valid_ff || rsp.ready) begin
            status_in = STATUS_FAIL;
            ridx_in   = 1'b0;
            orate_in  = '0;
            odiv_in   = '0;
            omul_in   = '0;
            valid_in  = 1'b1;
            state_in  = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      tgt_ff <= tgt_in; ref_ff <= ref_in; lo_ff <= lo_in; hi_ff <= hi_in;
      d_ff <= d_in; q_ff <= q_in; m_ff <= m_in; berr_ff <= berr_in;
      bmul_ff <= bmul_in; brate_ff <= brate_in; bdiv_ff <= bdiv_in;
      found_ff <= found_in; status_ff <= status_in; ridx_ff <= ridx_in;
      orate_ff <= orate_in; odiv_ff <= odiv_in; omul_ff <= omul_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp.valid         = valid_ff;
   assign rsp.status        = status_ff;
   assign rsp.best_rate     = orate_ff;
   assign rsp.divider       = odiv_ff;
   assign rsp.mul_minus_one = omul_ff;
   assign rsp.range_index   = ridx_ff;
endmodule

@@ design/pdms_divider.sv @@
// Radix-2 restoring divider, one quotient bit per cycle, 64-bit operands.
// Uses pdms_pkg for the control struct.
module pdms_divider import pdms_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WIDE_BITS-1:0] dividend,
   input  logic [WIDE_BITS-1:0] divisor,
   output div_ctl_type          ctl,
   output logic [WIDE_BITS-1:0] quotient,
   output logic [WIDE_BITS-1:0] remainder
);
   logic [WIDE_BITS-1:0] quo_ff, quo_in, rem_ff, rem_in, dsr_ff, dsr_in;
   logic [6:0]           cnt_ff, cnt_in;
   logic                 busy_ff, busy_in, done_ff, done_in;
   logic [WIDE_BITS:0]   shifted, diff;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[WIDE_BITS-1]};
      diff    = shifted - {1'b0, dsr_ff};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = 7'(WIDE_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[WIDE_BITS]) begin
            rem_in = diff[WIDE_BITS-1:0];
            quo_in = {quo_ff[WIDE_BITS-2:0], 1'b1};
         end else begin
            rem_in = shifted[WIDE_BITS-1:0];
            quo_in = {quo_ff[WIDE_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign ctl.start  = start;
   assign ctl.busy   = busy_ff;
   assign ctl.done   = done_ff;
   assign quotient   = quo_ff;
   assign remainder  = rem_ff;
endmodule

@@ sim/tb.sv @@
// Testbench for the PLL divider/multiplier search unit.
// Depends on design/pdms_pkg.sv, design/pdms_if.sv and the top-level RTL; holds its
// own predictor of the divider search and checks every result word in order.
`timescale 1ns / 1ps

module tb import pdms_pkg::*; ();

   localparam int          DIV_MAX    = 255;
   localparam int          IDLE_LIMIT = 200000;
   localparam longint unsigned RATE_TOP = 64'hFFFF_FFFF;

   typedef struct {
      logic        status;
      logic [31:0] best_rate;
      logic [7:0]  divider;
      logic [15:0] mul_minus_one;
      logic        range_index;
   } setting_type;

   logic clock;
   logic reset;

   pdms_req_if req_ch ();
   pdms_rsp_if rsp_ch ();
   pdms_csr_if csr_ch ();

   pll_divider_multiplier_search_unit #(.DIV_LIMIT(DIV_MAX)) dut (
      .clock(clock),
      .reset(reset),
      .req  (req_ch),
      .rsp  (rsp_ch),
      .csr  (csr_ch)
   );

   // register mirror
   logic [31:0] in_min_hz, in_max_hz;
   logic [11:0] mul_limit;
   logic [1:0]  ranges_used;
   logic [31:0] rng_lo [2];
   logic [31:0] rng_hi [2];

   setting_type expected_settings [$];
   int       mismatches;
   int       settings_seen;
   int       fails_seen;
   int       idle_cycles;
   int       burst_left;
   int       hold_left;
   int       stall_mode;
   int       mode_left;
   bit       long_hold_req;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic setting_type predict_setting(logic [31:0] tgt_in, logic [31:0] ref_in);
      longint unsigned t = tgt_in;
      longint unsigned r = ref_in;
      longint unsigned lo, hi, d, q, m, rate, err, tmp, used, i;
      longint unsigned best_err = 64'hFFFF_FFFF_FFFF_FFFF;
      longint unsigned best_div = 0, best_mul = 0, best_rate = 0;
      bit hit = 0;
      bit in_rng = 0;
      setting_type res;
      res.status = STATUS_FAIL;
      res.best_rate = '0;
      res.divider = '0;
      res.mul_minus_one = '0;
      res.range_index = 1'b0;
      if (r < in_min_hz || t == 0) return res;
      lo = (r * 2) / t;
      if (lo == 0) lo = 1;
      if (r > in_max_hz) begin
         if (in_max_hz == 0) return res;
         tmp = (r + in_max_hz - 1) / in_max_hz;
         if (tmp > DIV_MAX) return res;
         if (tmp > lo) lo = tmp;
      end
      hi = (r * mul_limit + t - 1) / t;
      if (hi > DIV_MAX) hi = DIV_MAX;
      for (d = lo; d <= hi; d++) begin
         q = r / d;
         if (q == 0) continue;
         m = (t + q / 2) / q;
         rate = q * m;
         err = (rate > t) ? rate - t : t - rate;
         if (err < best_err) begin
            best_err = err;
            best_div = d;
            best_mul = m;
            best_rate = rate;
            hit = 1;
         end
         if (err == 0) break;
      end
      if (!hit || best_mul == 0 || best_mul > mul_limit || best_rate > RATE_TOP) return res;
      used = (ranges_used < 2) ? ranges_used : 2;
      for (i = 0; i < used; i++) begin
         if (best_rate >= rng_lo[i] && best_rate <= rng_hi[i]) begin
            in_rng = 1;
            break;
         end
      end
      if (!in_rng) return res;
      res.status = STATUS_OK;
      res.best_rate = best_rate[31:0];
      res.divider = best_div[7:0];
      res.mul_minus_one = best_mul[15:0] - 16'd1;
      res.range_index = i[0];
      return res;
   endfunction

   task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
      $display("[%0t] mismatch %s: got %0h expected %0h", $realtime, what, got, want);
      mismatches++;
   endtask

   // request accept: predict with the config in force at that edge
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready)
         expected_settings.push_back(predict_setting(req_ch.target_rate, req_ch.reference_rate));
   end

   // register mirror follows accepted csr words
   always @(posedge clock) begin
      if (reset) begin
         in_min_hz <= '0;
         in_max_hz <= 32'hFFFF_FFFF;
         mul_limit <= 12'd2048;
         ranges_used <= 2'd1;
         rng_lo[0] <= '0;
         rng_hi[0] <= 32'hFFFF_FFFF;
         rng_lo[1] <= '0;
         rng_hi[1] <= 32'hFFFF_FFFF;
      end else if (csr_ch.valid && csr_ch.ready) begin
         case (csr_ch.index)
            CSR_INPUT_MIN:  in_min_hz <= csr_ch.data;
            CSR_INPUT_MAX:  in_max_hz <= csr_ch.data;
            CSR_MUL_MAX:    mul_limit <= csr_ch.data[11:0];
            CSR_RANGE_CNT:  ranges_used <= csr_ch.data[1:0];
            CSR_RANGE0_MIN: rng_lo[0] <= csr_ch.data;
            CSR_RANGE0_MAX: rng_hi[0] <= csr_ch.data;
            CSR_RANGE1_MIN: rng_lo[1] <= csr_ch.data;
            CSR_RANGE1_MAX: rng_hi[1] <= csr_ch.data;
            default: ;
         endcase
      end
   end

   // result checker
   always @(posedge clock) begin
      setting_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_settings.size() == 0) begin
            $display("[%0t] result word with nothing expected", $realtime);
            mismatches++;
         end else begin
            want = expected_settings.pop_front();
            settings_seen++;
            if (want.status == STATUS_FAIL) fails_seen++;
            if (rsp_ch.status !== want.status)
               report_mismatch("status", rsp_ch.status, want.status);
            if (rsp_ch.best_rate !== want.best_rate)
               report_mismatch("best_rate", rsp_ch.best_rate, want.best_rate);
            if (rsp_ch.divider !== want.divider)
               report_mismatch("divider", rsp_ch.divider, want.divider);
            if (rsp_ch.mul_minus_one !== want.mul_minus_one)
               report_mismatch("mul_minus_one", rsp_ch.mul_minus_one, want.mul_minus_one);
            if (rsp_ch.range_index !== want.range_index)
               report_mismatch("range_index", rsp_ch.range_index, want.range_index);
         end
      end
   end

   // receiver: stall pattern that changes mode now and then, plus long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_left <= 0;
         stall_mode <= 0;
         mode_left <= 100;
      end else begin
         if (long_hold_req && hold_left == 0) begin
            hold_left <= 4000;
            long_hold_req <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
         end
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            mode_left <= $urandom_range(20, 400);
         end else begin
            mode_left <= mode_left - 1;
         end
         if (hold_left > 0 || long_hold_req)
            rsp_ch.ready <= 1'b0;
         else case (stall_mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= ($urandom_range(0, 1) == 1);
            default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // watchdog on cycles with no word moving
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic send_request(logic [31:0] tgt, logic [31:0] refr);
      req_ch.valid <= 1'b1;
      req_ch.target_rate <= tgt;
      req_ch.reference_rate <= refr;
      forever begin
         @(posedge clock);
         if (req_ch.ready) break;
      end
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 30)) @(posedge clock);
         burst_left = $urandom_range(0, 6);
      end
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_settings.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= value;
      forever begin
         @(posedge clock);
         if (csr_ch.ready) break;
      end
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic restore_defaults();
      wait_drained();
      write_reg(CSR_INPUT_MIN, 32'd0);
      write_reg(CSR_INPUT_MAX, 32'hFFFF_FFFF);
      write_reg(CSR_MUL_MAX, 32'd2048);
      write_reg(CSR_RANGE_CNT, 32'd1);
      write_reg(CSR_RANGE0_MIN, 32'd0);
      write_reg(CSR_RANGE0_MAX, 32'hFFFF_FFFF);
      write_reg(CSR_RANGE1_MIN, 32'd0);
      write_reg(CSR_RANGE1_MAX, 32'hFFFF_FFFF);
   endtask

   // reset config: extremes of both fields, zero target, empty search, full sweeps
   task automatic test_field_extremes();
      send_request(32'd1, 32'd0);
      send_request(32'd0, 32'd1000);
      send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(32'd1, 32'hFFFF_FFFF);
      send_request(32'd12_000_000, 32'd12_000_000);
      send_request(32'd48_000_000, 32'd12_000_000);
      // no exact match: walks every divider up to the cap
      send_request(32'd16_000_001, 32'd12_000_000);
      send_request(32'hFFFF_FFFF, 32'd3);
      wait_drained();
   endtask

   task automatic test_input_limits();
      write_reg(CSR_INPUT_MIN, 32'd1000);
      write_reg(CSR_INPUT_MAX, 32'd10000);
      write_reg(CSR_MUL_MAX, 32'd16);
      send_request(32'd5000, 32'd999);
      send_request(32'd5000, 32'd1000);
      send_request(32'd40000, 32'd20000);
      send_request(32'd3_000_000, 32'd3_000_000);  // predivide beyond divider cap
      send_request(32'd30000, 32'd25_000);
      wait_drained();
      write_reg(CSR_INPUT_MAX, 32'd0);
      send_request(32'd1000, 32'd1000);
      send_request(32'd1000, 32'd0);
      wait_drained();
      write_reg(CSR_INPUT_MIN, 32'hFFFF_FFFF);
      write_reg(CSR_INPUT_MAX, 32'hFFFF_FFFF);
      send_request(32'hFFFF_FFFE, 32'hFFFF_FFFE);
      send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      restore_defaults();
   endtask

   task automatic test_mul_limit();
      write_reg(CSR_MUL_MAX, 32'd0);
      send_request(32'd1000, 32'd1000);
      wait_drained();
      write_reg(CSR_MUL_MAX, 32'd1);
      send_request(32'd3000, 32'd1000);
      send_request(32'd1000, 32'd1000);
      wait_drained();
      write_reg(CSR_MUL_MAX, 32'd2);
      send_request(32'd1500, 32'd1000);
      send_request(32'd9000, 32'd1000);
      wait_drained();
      write_reg(CSR_MUL_MAX, 32'hFFFF_FFFF);  // masks to the full 12-bit field
      send_request(32'd4_000_000, 32'd1_000_000);
      restore_defaults();
   endtask

   task automatic test_output_ranges();
      write_reg(CSR_MUL_MAX, 32'd8);
      write_reg(CSR_RANGE_CNT, 32'd0);
      send_request(32'd2000, 32'd1000);
      wait_drained();
      write_reg(CSR_RANGE_CNT, 32'd2);
      write_reg(CSR_RANGE0_MIN, 32'd100);
      write_reg(CSR_RANGE0_MAX, 32'd1999);
      write_reg(CSR_RANGE1_MIN, 32'd2000);
      write_reg(CSR_RANGE1_MAX, 32'd2000);
      send_request(32'd2000, 32'd1000);
      send_request(32'd1500, 32'd1000);
      send_request(32'd4000, 32'd1000);
      wait_drained();
      write_reg(CSR_RANGE_CNT, 32'd3);
      send_request(32'd2000, 32'd1000);
      wait_drained();
      write_reg(CSR_RANGE_CNT, 32'd1);
      send_request(32'd2000, 32'd1000);
      restore_defaults();
   endtask

   task automatic random_request(int rmax);
      logic [31:0] refr, tgt;
      int pick;
      pick = $urandom_range(0, 9);
      refr = (pick < 2) ? $urandom_range(0, 5000) : $urandom;
      if (pick < 6)
         // near-reachable rate: some divider and multiplier, plus an offset of 0 to 3
         tgt = (refr / $urandom_range(1, 20)) * $urandom_range(1, rmax) + $urandom_range(0, 3);
      else
         tgt = $urandom;
      if (tgt == 0 && $urandom_range(0, 3) != 0) tgt = 32'd1;
      send_request(tgt, refr);
   endtask

   task automatic test_random_settings();
      int rmax;
      for (int phase = 0; phase < 6; phase++) begin
         wait_drained();
         rmax = $urandom_range(2, 16);
         write_reg(CSR_MUL_MAX, rmax);
         write_reg(CSR_INPUT_MIN, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 100000) : 0);
         write_reg(CSR_INPUT_MAX, ($urandom_range(0, 1) == 0) ? $urandom : 32'hFFFF_FFFF);
         write_reg(CSR_RANGE_CNT, $urandom_range(1, 2));
         write_reg(CSR_RANGE0_MIN, $urandom_range(0, 1000));
         write_reg(CSR_RANGE0_MAX, ($urandom_range(0, 1) == 0) ? $urandom : 32'hFFFF_FFFF);
         write_reg(CSR_RANGE1_MIN, $urandom >> $urandom_range(0, 31));
         write_reg(CSR_RANGE1_MAX, 32'hFFFF_FFFF);
         repeat (12) random_request(rmax);
      end
      restore_defaults();
   endtask

   // receiver holds off while requests keep coming
   task automatic test_backpressure();
      write_reg(CSR_MUL_MAX, 32'd4);
      long_hold_req = 1'b1;
      burst_left = 8;
      repeat (8) random_request(4);
      wait_drained();
      restore_defaults();
   endtask

   initial begin
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.target_rate <= '0;
      req_ch.reference_rate <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= CSR_INPUT_MIN;
      csr_ch.data <= '0;
      mismatches = 0;
      settings_seen = 0;
      fails_seen = 0;
      burst_left = 0;
      long_hold_req = 1'b0;
      idle_cycles = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_field_extremes();
      test_input_limits();
      test_mul_limit();
      test_output_ranges();
      test_random_settings();
      test_backpressure();

      wait_drained();
      repeat (50) @(posedge clock);
      if (expected_settings.size() != 0) begin
         $display("%0d result words never arrived", expected_settings.size());
         mismatches++;
      end
      $display("checked %0d search results (%0d out of range) across limit, multiplier,",
               settings_seen, fails_seen);
      $display("range-count and random register settings with stalls on both sides");
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
